// ===== design/lscd_pkg.sv =====
// shared constants and helper functions for the lidar scan corner detector
package lscd_pkg;

	localparam int RANGE_W = 16;
	localparam int COORD_W = 17;
	localparam int COUNT_W = 11;
	localparam int SEG_CAP = 1024;
	localparam int COUNT_MAX = 2047;

	// q16 gain-compensated start value of the rotation unit
	localparam logic [15:0] CORDIC_K = 16'd39797;

	typedef enum logic [2:0] {
		REG_GAP       = 3'd0,
		REG_MIN_PTS   = 3'd1,
		REG_CORNER    = 3'd2,
		REG_RANGE_MIN = 3'd3,
		REG_RANGE_MAX = 3'd4,
		REG_START     = 3'd5,
		REG_STEP      = 3'd6
	} cfg_reg_t;

	// arctan(2^-i) in units of 2pi/2^32
	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// clamp a rounded coordinate to +-65535 mm
	function automatic logic signed [16:0] sat_mm(input logic signed [19:0] v);
		logic signed [16:0] r;
		if (v > 20'sd65535) r = 17'sd65535;
		else if (v < -20'sd65535) r = -17'sd65535;
		else r = v[16:0];
		return r;
	endfunction

endpackage

// ===== design/lidar_scan_corner_detector.sv =====
// lidar scan corner detector: beam to point, segmentation, pca line angle, corners
//
//  channel  | direction | signals                                   | payload
//  ---------+-----------+-------------------------------------------+---------------------------
//  s_axis   | in        | tvalid tready tdata[15:0] tuser tlast     | range_mm, range_ok, last_beam
//  m_axis   | out       | tvalid tready tdata[47:0] tuser tlast     | corner x/y/count, kind, last
//  cfg      | in        | valid ready index[2:0] data[15:0]         | register writes
//
// a beam with a point passes through the multiply, rotation, rounding, gap and accumulate
// steps in the sequencer; closing a kept segment adds the covariance, normalizing shift,
// vectoring and corner steps, all on the shared rotation, multiplier and shift datapath
// s_axis_tready is high only while the sequencer is idle; results wait in one output
// register, and the sequencer stalls in an emit step while that register is full
// arst_n clears all scan state and loads the register reset values
module lidar_scan_corner_detector #(
	parameter int MAX_BEAMS    = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] range_mm
	input  logic        s_axis_tuser,   // [0] range_ok
	input  logic        s_axis_tlast,   // last_beam
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [16:0] corner_x_mm, [33:17] corner_y_mm,
	                                    // [44:34] corner_count, [47:45] zero
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast,   // set on the summary and on corners before the last beam
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_BEAMS + 1);
	localparam int IT_W  = $clog2(CORDIC_STEPS);

	typedef enum logic [25:0] {
		ST_IDLE  = 26'h0000001,
		ST_MUL0  = 26'h0000002,
		ST_ROT   = 26'h0000004,
		ST_ROUND = 26'h0000008,
		ST_GAP1  = 26'h0000010,
		ST_GAP2  = 26'h0000020,
		ST_GAP3  = 26'h0000040,
		ST_GAP4  = 26'h0000080,
		ST_ADD   = 26'h0000100,
		ST_SQXX  = 26'h0000200,
		ST_SQYY  = 26'h0000400,
		ST_SQXY  = 26'h0000800,
		ST_SQEND = 26'h0001000,
		ST_CLOSE = 26'h0002000,
		ST_C1    = 26'h0004000,
		ST_C2    = 26'h0008000,
		ST_C3    = 26'h0010000,
		ST_C4    = 26'h0020000,
		ST_NORM  = 26'h0040000,
		ST_VINIT = 26'h0080000,
		ST_VEC   = 26'h0100000,
		ST_PHI   = 26'h0200000,
		ST_CMP   = 26'h0400000,
		ST_EMITC = 26'h0800000,
		ST_CFIN  = 26'h1000000,
		ST_SUMM  = 26'h2000000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] gap_q, rmin_q, rmax_q, start_q, step_q;
	logic [10:0] min_pts_q;
	logic [14:0] corner_q;

	// beam
	logic [15:0]      range_q;
	logic             last_q;
	logic [1:0]       quad_q;
	logic [15:0]      beam_angle_q;
	logic [CNT_W-1:0] beam_count_q;

	// rotation / vectoring unit
	logic signed [34:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic signed [33:0] va_q, vb_q;
	logic [31:0]        vz_q;
	logic [IT_W-1:0]    it_q;

	// points and segment
	logic signed [16:0] pt_x_q, pt_y_q, last_x_q, last_y_q, first_x_q, first_y_q;
	logic               have_point_q;
	logic [10:0]        seg_points_q;
	logic signed [27:0] sum_x_q, sum_y_q;
	logic signed [42:0] sum_xx_q, sum_yy_q;
	logic signed [43:0] sum_xy_q;
	logic signed [36:0] acc_q;
	logic               ret_add_q;

	// pca
	logic signed [57:0] prod_q;
	logic signed [55:0] pn_q, a_q, b_q;
	logic [15:0]        phi_q;
	logic               prev_valid_q;
	logic [15:0]        prev_angle_q;
	logic signed [16:0] prev_end_x_q, prev_end_y_q;
	logic [10:0]        corners_q;

	// output register
	logic               out_valid_q, out_kind_q, out_last_q;
	logic signed [16:0] out_x_q, out_y_q;
	logic [10:0]        out_cnt_q;

	// shared multipliers
	logic signed [28:0] mw_a, mw_b;
	logic signed [57:0] mw_p;
	logic signed [43:0] mn_b;
	logic signed [55:0] mn_p;

	always_comb begin
		mw_a = '0;
		mw_b = '0;
		mn_b = '0;
		case (state_q)
			ST_GAP1: begin
				mw_a = 29'(18'(pt_x_q) - 18'(last_x_q));
				mw_b = mw_a;
			end
			ST_GAP2: begin
				mw_a = 29'(18'(pt_y_q) - 18'(last_y_q));
				mw_b = mw_a;
			end
			ST_GAP3: begin
				mw_a = $signed({13'd0, gap_q});
				mw_b = mw_a;
			end
			ST_SQXX: begin
				mw_a = 29'(pt_x_q);
				mw_b = 29'(pt_x_q);
			end
			ST_SQYY: begin
				mw_a = 29'(pt_y_q);
				mw_b = 29'(pt_y_q);
			end
			ST_SQXY: begin
				mw_a = 29'(pt_x_q);
				mw_b = 29'(pt_y_q);
			end
			ST_C1: begin
				mw_a = 29'(sum_x_q);
				mw_b = 29'(sum_x_q);
				mn_b = 44'(sum_xx_q);
			end
			ST_C2: begin
				mw_a = 29'(sum_y_q);
				mw_b = 29'(sum_y_q);
				mn_b = 44'(sum_yy_q);
			end
			ST_C3: begin
				mw_a = 29'(sum_x_q);
				mw_b = 29'(sum_y_q);
				mn_b = sum_xy_q;
			end
			default: begin
				mw_a = '0;
			end
		endcase
	end

	assign mw_p = mw_a * mw_b;
	assign mn_p = $signed({1'b0, seg_points_q}) * mn_b;

	// beam angle and polar reduction at acceptance
	logic        in_xfer, beam_valid;
	logic [15:0] beam_a, quad_sum, res_a;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign beam_a        = (beam_count_q == '0) ? start_q : beam_angle_q;
	assign quad_sum      = beam_a + 16'h2000;
	assign res_a         = beam_a - {quad_sum[15:14], 14'd0};
	assign beam_valid    = s_axis_tuser && (s_axis_tdata >= rmin_q) &&
	                       (s_axis_tdata <= rmax_q) && (beam_count_q < CNT_W'(MAX_BEAMS));

	// rotation step
	logic [31:0]        atan_i;
	logic signed [34:0] cx_sh, cy_sh;
	logic signed [33:0] va_sh, vb_sh;

	assign atan_i = lscd_pkg::atan_val(5'(it_q));
	assign cx_sh  = cx_q >>> it_q;
	assign cy_sh  = cy_q >>> it_q;
	assign va_sh  = va_q >>> it_q;
	assign vb_sh  = vb_q >>> it_q;

	// rounding and quadrant mapping
	logic signed [34:0] cx_rnd, cy_rnd;
	logic signed [19:0] xr, yr, px, py;

	assign cx_rnd = cx_q + 35'sd32768;
	assign cy_rnd = cy_q + 35'sd32768;
	assign xr     = 20'($signed(cx_rnd[34:16]));
	assign yr     = 20'($signed(cy_rnd[34:16]));

	always_comb begin
		case (quad_q)
			2'd0: begin
				px = xr;
				py = yr;
			end
			2'd1: begin
				px = -yr;
				py = xr;
			end
			2'd2: begin
				px = -xr;
				py = -yr;
			end
			default: begin
				px = yr;
				py = -xr;
			end
		endcase
	end

	// normalization tests
	logic signed [55:0] abs_a, abs_b, cdiff;
	logic               big, tiny;

	assign abs_a = a_q[55] ? -a_q : a_q;
	assign abs_b = b_q[55] ? -b_q : b_q;
	assign big   = (abs_a >= 56'sd1073741824) || (abs_b >= 56'sd1073741824);
	assign tiny  = (abs_a < 56'sd536870912) && (abs_b < 56'sd536870912);
	assign cdiff = pn_q - prod_q[55:0];

	// corner test
	logic [15:0] dang;
	logic [16:0] abs_d;
	logic        is_corner;
	logic [17:0] mid_x, mid_y;

	assign dang      = phi_q - prev_angle_q;
	assign abs_d     = dang[15] ? (17'd0 - {1'b1, dang}) : {1'b0, dang};
	assign is_corner = prev_valid_q && (abs_d > {1'b0, corner_q, 1'b0});
	assign mid_x     = 18'(prev_end_x_q) + 18'(first_x_q);
	assign mid_y     = 18'(prev_end_y_q) + 18'(first_y_q);

	logic seg_keep, it_done;
	assign seg_keep = (seg_points_q != '0) && (seg_points_q >= min_pts_q);
	assign it_done  = (it_q == IT_W'(CORDIC_STEPS - 1));

	state_t ret_state;
	assign ret_state = ret_add_q ? ST_ADD : ST_SUMM;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q     <= 16'd300;
			min_pts_q <= 11'd3;
			corner_q  <= 15'd3641;
			rmin_q    <= 16'd0;
			rmax_q    <= 16'd65535;
			start_q   <= 16'd0;
			step_q    <= 16'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				lscd_pkg::REG_GAP:       gap_q     <= cfg_data;
				lscd_pkg::REG_MIN_PTS:   min_pts_q <= cfg_data[10:0];
				lscd_pkg::REG_CORNER:    corner_q  <= cfg_data[14:0];
				lscd_pkg::REG_RANGE_MIN: rmin_q    <= cfg_data;
				lscd_pkg::REG_RANGE_MAX: rmax_q    <= cfg_data;
				lscd_pkg::REG_START:     start_q   <= cfg_data;
				lscd_pkg::REG_STEP:      step_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= mw_p;
		pn_q   <= mn_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			range_q      <= '0;
			last_q       <= 1'b0;
			quad_q       <= '0;
			beam_angle_q <= '0;
			beam_count_q <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
			va_q         <= '0;
			vb_q         <= '0;
			vz_q         <= '0;
			it_q         <= '0;
			pt_x_q       <= '0;
			pt_y_q       <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			have_point_q <= 1'b0;
			seg_points_q <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_xx_q     <= '0;
			sum_yy_q     <= '0;
			sum_xy_q     <= '0;
			acc_q        <= '0;
			ret_add_q    <= 1'b0;
			a_q          <= '0;
			b_q          <= '0;
			phi_q        <= '0;
			prev_valid_q <= 1'b0;
			prev_angle_q <= '0;
			prev_end_x_q <= '0;
			prev_end_y_q <= '0;
			corners_q    <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= 1'b0;
			out_last_q   <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						range_q      <= s_axis_tdata;
						last_q       <= s_axis_tlast;
						quad_q       <= quad_sum[15:14];
						cz_q         <= {res_a[15], res_a, 16'd0};
						beam_angle_q <= beam_a + step_q;
						if (beam_count_q < CNT_W'(MAX_BEAMS)) beam_count_q <= beam_count_q + 1'b1;
						ret_add_q    <= 1'b0;
						if (beam_valid) state_q <= ST_MUL0;
						else if (s_axis_tlast) state_q <= ST_CLOSE;
					end
				end
				ST_MUL0: begin
					cx_q    <= $signed({3'd0, 32'(range_q) * 32'(lscd_pkg::CORDIC_K)});
					cy_q    <= '0;
					it_q    <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (!cz_q[32]) begin
						cx_q <= cx_q - cy_sh;
						cy_q <= cy_q + cx_sh;
						cz_q <= cz_q - $signed({1'b0, atan_i});
					end else begin
						cx_q <= cx_q + cy_sh;
						cy_q <= cy_q - cx_sh;
						cz_q <= cz_q + $signed({1'b0, atan_i});
					end
					it_q <= it_q + 1'b1;
					if (it_done) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					pt_x_q  <= lscd_pkg::sat_mm(px);
					pt_y_q  <= lscd_pkg::sat_mm(py);
					state_q <= have_point_q ? ST_GAP1 : ST_ADD;
				end
				ST_GAP1: state_q <= ST_GAP2;
				ST_GAP2: begin
					acc_q   <= prod_q[36:0];
					state_q <= ST_GAP3;
				end
				ST_GAP3: begin
					acc_q   <= acc_q + prod_q[36:0];
					state_q <= ST_GAP4;
				end
				ST_GAP4: begin
					if (acc_q > prod_q[36:0]) begin
						ret_add_q <= 1'b1;
						state_q   <= ST_CLOSE;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					ret_add_q <= 1'b0;
					if (seg_points_q == '0) begin
						first_x_q <= pt_x_q;
						first_y_q <= pt_y_q;
					end
					last_x_q     <= pt_x_q;
					last_y_q     <= pt_y_q;
					have_point_q <= 1'b1;
					if (seg_points_q < 11'(lscd_pkg::SEG_CAP)) begin
						seg_points_q <= seg_points_q + 1'b1;
						sum_x_q      <= sum_x_q + 28'(pt_x_q);
						sum_y_q      <= sum_y_q + 28'(pt_y_q);
						state_q      <= ST_SQXX;
					end else begin
						state_q <= last_q ? ST_CLOSE : ST_IDLE;
					end
				end
				ST_SQXX: state_q <= ST_SQYY;
				ST_SQYY: begin
					sum_xx_q <= sum_xx_q + prod_q[42:0];
					state_q  <= ST_SQXY;
				end
				ST_SQXY: begin
					sum_yy_q <= sum_yy_q + prod_q[42:0];
					state_q  <= ST_SQEND;
				end
				ST_SQEND: begin
					sum_xy_q <= sum_xy_q + prod_q[43:0];
					state_q  <= last_q ? ST_CLOSE : ST_IDLE;
				end
				ST_CLOSE: begin
					if (seg_keep) begin
						state_q <= ST_C1;
					end else begin
						seg_points_q <= '0;
						sum_x_q      <= '0;
						sum_y_q      <= '0;
						sum_xx_q     <= '0;
						sum_yy_q     <= '0;
						sum_xy_q     <= '0;
						state_q      <= ret_state;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: begin
					a_q     <= cdiff;
					state_q <= ST_C3;
				end
				ST_C3: begin
					a_q     <= a_q - cdiff;
					state_q <= ST_C4;
				end
				ST_C4: begin
					b_q     <= cdiff <<< 1;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (a_q == '0 && b_q == '0) begin
						phi_q   <= '0;
						state_q <= ST_CMP;
					end else if (big) begin
						a_q <= a_q >>> 1;
						b_q <= b_q >>> 1;
					end else if (tiny) begin
						a_q <= a_q <<< 1;
						b_q <= b_q <<< 1;
					end else begin
						state_q <= ST_VINIT;
					end
				end
				ST_VINIT: begin
					if (a_q[55]) begin
						va_q <= -a_q[33:0];
						vb_q <= -b_q[33:0];
						vz_q <= 32'h8000_0000;
					end else begin
						va_q <= a_q[33:0];
						vb_q <= b_q[33:0];
						vz_q <= '0;
					end
					it_q    <= '0;
					state_q <= ST_VEC;
				end
				ST_VEC: begin
					if (vb_q[33]) begin
						va_q <= va_q - vb_sh;
						vb_q <= vb_q + va_sh;
						vz_q <= vz_q - atan_i;
					end else begin
						va_q <= va_q + vb_sh;
						vb_q <= vb_q - va_sh;
						vz_q <= vz_q + atan_i;
					end
					it_q <= it_q + 1'b1;
					if (it_done) state_q <= ST_PHI;
				end
				ST_PHI: begin
					phi_q   <= 16'((vz_q + 32'h8000) >> 16);
					state_q <= ST_CMP;
				end
				ST_CMP: state_q <= is_corner ? ST_EMITC : ST_CFIN;
				ST_EMITC: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b0;
						out_x_q     <= $signed(mid_x[17:1]);
						out_y_q     <= $signed(mid_y[17:1]);
						out_cnt_q   <= '0;
						out_last_q  <= !last_q;
						if (corners_q < 11'(lscd_pkg::COUNT_MAX)) corners_q <= corners_q + 1'b1;
						state_q     <= ST_CFIN;
					end
				end
				ST_CFIN: begin
					prev_valid_q <= 1'b1;
					prev_angle_q <= phi_q;
					prev_end_x_q <= last_x_q;
					prev_end_y_q <= last_y_q;
					seg_points_q <= '0;
					sum_x_q      <= '0;
					sum_y_q      <= '0;
					sum_xx_q     <= '0;
					sum_yy_q     <= '0;
					sum_xy_q     <= '0;
					state_q      <= ret_state;
				end
				ST_SUMM: begin
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= 1'b1;
						out_x_q      <= '0;
						out_y_q      <= '0;
						out_cnt_q    <= corners_q;
						out_last_q   <= 1'b1;
						// scan state back to its start
						beam_angle_q <= start_q;
						beam_count_q <= '0;
						have_point_q <= 1'b0;
						last_x_q     <= '0;
						last_y_q     <= '0;
						first_x_q    <= '0;
						first_y_q    <= '0;
						seg_points_q <= '0;
						sum_x_q      <= '0;
						sum_y_q      <= '0;
						sum_xx_q     <= '0;
						sum_yy_q     <= '0;
						sum_xy_q     <= '0;
						prev_valid_q <= 1'b0;
						prev_angle_q <= '0;
						prev_end_x_q <= '0;
						prev_end_y_q <= '0;
						corners_q    <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_cnt_q, out_y_q, out_x_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule
